// ===== src/lts_pkg.sv =====
// Shared types and constants for the LED text scroll column engine.
// No dependencies; imported by every module of the block.
package lts_pkg;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_GLYPH = 2'd2,
        OP_WIDTH = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN_REQ,
        ST_DRAIN_CHK,
        ST_GLYPH_REQ,
        ST_GLYPH_OUT
    } state_t;

    // Classified word handed from the front to the back.
    typedef struct packed {
        op_t         op;
        logic [7:0]  value_byte;
        logic [7:0]  glyph_code;
        logic [2:0]  glyph_column;
        logic [63:0] column_pixels;
        logic [3:0]  glyph_width;   // already clamped to 1..MAX_GLYPH_WIDTH
        logic        write_ok;      // glyph/width write lands inside the store
    } item_t;

    typedef struct packed {
        logic [63:0] red_column;
        logic [63:0] green_column;
        logic [63:0] blue_column;
        logic        screen_blank;
        logic        overflow;
    } res_t;

    localparam int          CMDQ_DEPTH        = 2;
    localparam int          CMDQ_AW           = 1;
    localparam logic [7:0]  COLOR_CMD_MAX     = 8'h0F;
    localparam logic [3:0]  BLANK_SCREEN_COLS = 4'd8;
    localparam logic [3:0]  RESET_LEVEL       = 4'd2;
    localparam logic [3:0]  DEFAULT_WIDTH     = 4'd1;

    // Each pixel byte times a 4-bit level, kept to 8 bits.
    function automatic logic [63:0] scale_column(input logic [63:0] px,
                                                 input logic [3:0] level);
        logic [63:0] r;
        logic [11:0] prod;
        r = '0;
        for (int row = 0; row < 8; row++)
        begin
            prod = px[8*row +: 8] * level;
            r[8*row +: 8] = prod[7:0];
        end
        return r;
    endfunction

endpackage

// ===== src/lts_front.sv =====
// Front end: accepts input words, classifies them and holds them in a
// two-entry command queue for the back end. Depends on lts_pkg.
module lts_front import lts_pkg::*; #(
    parameter int MAX_GLYPH_WIDTH = 8,
    parameter int CHAR_COUNT      = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [7:0]  value_byte,
    input  logic [7:0]  glyph_code,
    input  logic [2:0]  glyph_column,
    input  logic [63:0] column_pixels,
    input  logic [3:0]  glyph_width,
    output logic        cmd_valid,
    output item_t       cmd_item,
    input  logic        cmd_pop
);

    item_t                queue_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg;
    logic [CMDQ_AW-1:0]   rd_ptr_reg;
    logic [CMDQ_AW:0]     count_reg;
    item_t                item_in;
    logic                 do_push;
    logic                 do_pop;

    always_comb
    begin
        item_in.op            = op_t'(command);
        item_in.value_byte    = value_byte;
        item_in.glyph_code    = glyph_code;
        item_in.glyph_column  = glyph_column;
        item_in.column_pixels = column_pixels;
        if (glyph_width == 4'd0)
            item_in.glyph_width = DEFAULT_WIDTH;
        else if (int'(glyph_width) > MAX_GLYPH_WIDTH)
            item_in.glyph_width = 4'(MAX_GLYPH_WIDTH);
        else
            item_in.glyph_width = glyph_width;
        case (op_t'(command))
            OP_GLYPH: item_in.write_ok = (int'(glyph_code) < CHAR_COUNT) &&
                                         (int'(glyph_column) < MAX_GLYPH_WIDTH);
            OP_WIDTH: item_in.write_ok = (int'(glyph_code) < CHAR_COUNT);
            default:  item_in.write_ok = 1'b0;
        endcase
    end

    assign full      = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_item  = queue_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            queue_reg[wr_ptr_reg] <= item_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== src/lts_back.sv =====
// Back end: byte queue, glyph stores and the tick sequencer that drains
// color commands and builds each new column. Depends on lts_pkg.
module lts_back import lts_pkg::*; #(
    parameter int QUEUE_DEPTH     = 16,
    parameter int MAX_GLYPH_WIDTH = 8,
    parameter int GAP_COLS        = 1,
    parameter int CHAR_COUNT      = 256
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    input  item_t cmd_item,
    output logic  cmd_pop,
    output logic  res_valid,
    output res_t  res,
    input  logic  res_ready
);

    localparam int QA_W  = $clog2(QUEUE_DEPTH);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CA_W  = $clog2(CHAR_COUNT);
    localparam int GDEP  = CHAR_COUNT * MAX_GLYPH_WIDTH;
    localparam int GA_W  = $clog2(GDEP);

    state_t            state_reg, state_next;

    logic [7:0]        byte_mem [QUEUE_DEPTH];
    logic [63:0]       glyph_mem [GDEP];
    logic [3:0]        width_mem [CHAR_COUNT];
    logic              width_valid_reg [CHAR_COUNT];

    logic [QA_W-1:0]   head_reg, tail_reg;
    logic [QC_W-1:0]   count_reg;
    logic              await_reg;
    logic [3:0]        red_reg, green_reg, blue_reg;
    logic [7:0]        cur_char_reg;
    logic [3:0]        col_idx_reg;
    logic              drawing_reg;
    logic [3:0]        blank_cols_reg;
    logic              blank_flag_reg;
    logic              dropped_reg;

    logic [7:0]        byte_rd_reg;
    logic [63:0]       glyph_rd_reg;
    logic [3:0]        width_rd_reg;
    logic              width_vld_rd_reg;

    // control decoded from the state
    logic              q_full, q_empty;
    logic              is_color, in_space;
    logic              do_push, do_drop, glyph_we, width_we;
    logic              color_pop, start_char, emit_blank, emit_glyph;
    logic              char_ok;
    logic [3:0]        eff_width;
    logic [3:0]        col_inc;
    logic [3:0]        blank_cols_inc;
    logic              blank_flag_new;
    logic [63:0]       px;
    logic [GA_W-1:0]   wr_addr, rd_addr;

    assign q_full    = (count_reg == QC_W'(QUEUE_DEPTH));
    assign q_empty   = (count_reg == '0);
    assign is_color  = await_reg || (byte_rd_reg <= COLOR_CMD_MAX);
    assign in_space  = (int'(col_idx_reg) < GAP_COLS);
    assign char_ok   = (int'(cur_char_reg) < CHAR_COUNT);
    assign eff_width = (char_ok && width_vld_rd_reg) ? width_rd_reg : DEFAULT_WIDTH;
    assign col_inc   = col_idx_reg + 4'd1;
    assign blank_cols_inc = blank_cols_reg + 4'd1;
    assign blank_flag_new = blank_flag_reg || (blank_cols_inc == BLANK_SCREEN_COLS);
    assign px        = char_ok ? glyph_rd_reg : '0;
    assign wr_addr   = GA_W'(int'(cmd_item.glyph_code) * MAX_GLYPH_WIDTH +
                             int'(cmd_item.glyph_column));
    assign rd_addr   = GA_W'(int'(cur_char_reg) * MAX_GLYPH_WIDTH + int'(col_idx_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (cmd_valid && cmd_item.op == OP_TICK)
                    state_next = drawing_reg ? ST_GLYPH_REQ : ST_DRAIN_REQ;
            ST_DRAIN_REQ:
                if (!q_empty)
                    state_next = ST_DRAIN_CHK;
                else if (res_ready)
                    state_next = ST_IDLE;
            ST_DRAIN_CHK:
                if (is_color)
                    state_next = ST_DRAIN_REQ;
                else if (!in_space)
                    state_next = ST_GLYPH_REQ;
                else if (res_ready)
                    state_next = ST_IDLE;
            ST_GLYPH_REQ:
                state_next = ST_GLYPH_OUT;
            ST_GLYPH_OUT:
                if (res_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and strobes
    always_comb
    begin
        cmd_pop    = (state_reg == ST_IDLE) && cmd_valid;
        do_push    = cmd_pop && cmd_item.op == OP_BYTE && !q_full;
        do_drop    = cmd_pop && cmd_item.op == OP_BYTE && q_full;
        glyph_we   = cmd_pop && cmd_item.op == OP_GLYPH && cmd_item.write_ok;
        width_we   = cmd_pop && cmd_item.op == OP_WIDTH && cmd_item.write_ok;
        color_pop  = (state_reg == ST_DRAIN_CHK) && is_color;
        start_char = (state_reg == ST_DRAIN_CHK) && !is_color && !in_space;
        emit_blank = res_ready &&
                     (((state_reg == ST_DRAIN_REQ) && q_empty) ||
                      ((state_reg == ST_DRAIN_CHK) && !is_color && in_space));
        emit_glyph = res_ready && (state_reg == ST_GLYPH_OUT);
        res_valid  = emit_blank || emit_glyph;

        res.overflow = dropped_reg;
        if (emit_glyph)
        begin
            res.red_column   = scale_column(px, red_reg);
            res.green_column = scale_column(px, green_reg);
            res.blue_column  = scale_column(px, blue_reg);
            res.screen_blank = blank_flag_reg;
        end
        else
        begin
            res.red_column   = '0;
            res.green_column = '0;
            res.blue_column  = '0;
            res.screen_blank = blank_flag_new;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (do_push)
            byte_mem[tail_reg] <= cmd_item.value_byte;
        if (state_reg == ST_DRAIN_REQ)
            byte_rd_reg <= byte_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (glyph_we)
            glyph_mem[wr_addr] <= cmd_item.column_pixels;
        if (state_reg == ST_GLYPH_REQ)
            glyph_rd_reg <= glyph_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (width_we)
            width_mem[cmd_item.glyph_code[CA_W-1:0]] <= cmd_item.glyph_width;
        if (state_reg == ST_GLYPH_REQ)
        begin
            width_rd_reg     <= width_mem[cur_char_reg[CA_W-1:0]];
            width_vld_rd_reg <= width_valid_reg[cur_char_reg[CA_W-1:0]];
        end
    end

    // unwritten width entries read as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAR_COUNT; i++)
                width_valid_reg[i] <= 1'b0;
        end
        else if (width_we)
        begin
            width_valid_reg[cmd_item.glyph_code[CA_W-1:0]] <= 1'b1;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            await_reg      <= 1'b0;
            red_reg        <= RESET_LEVEL;
            green_reg      <= RESET_LEVEL;
            blue_reg       <= RESET_LEVEL;
            cur_char_reg   <= '0;
            col_idx_reg    <= 4'(GAP_COLS);
            drawing_reg    <= 1'b0;
            blank_cols_reg <= BLANK_SCREEN_COLS;
            blank_flag_reg <= 1'b1;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (do_push)
            begin
                tail_reg  <= (tail_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            if (do_drop)
                dropped_reg <= 1'b1;

            if (color_pop || start_char)
            begin
                head_reg  <= (head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_reg <= count_reg - 1'b1;
            end

            if (color_pop)
            begin
                if (await_reg)
                begin
                    green_reg <= byte_rd_reg[7:4];
                    blue_reg  <= byte_rd_reg[3:0];
                end
                else
                begin
                    red_reg <= byte_rd_reg[3:0];
                end
                await_reg <= !await_reg;
            end

            if (start_char)
            begin
                cur_char_reg   <= byte_rd_reg;
                drawing_reg    <= 1'b1;
                col_idx_reg    <= '0;
                blank_flag_reg <= 1'b0;
                blank_cols_reg <= '0;
            end

            if (emit_blank)
            begin
                if (in_space)
                    col_idx_reg <= col_inc;
                if (!blank_flag_reg)
                begin
                    blank_cols_reg <= blank_cols_inc;
                    blank_flag_reg <= blank_flag_new;
                end
            end

            if (emit_glyph)
            begin
                if (col_inc >= eff_width)
                begin
                    drawing_reg <= 1'b0;
                    col_idx_reg <= '0;
                end
                else
                begin
                    col_idx_reg <= col_inc;
                end
            end

            if (emit_blank || emit_glyph)
                dropped_reg <= 1'b0;
        end
    end

endmodule

// ===== src/led_text_scroll_column_engine.sv =====
// Top level of the LED text scroll column engine: front end, back end and
// the result register. Depends on lts_pkg, lts_front and lts_back.
//
// Usage
//   Input side is a queue: drive command and its fields with push; the word
//   is taken on a clock edge with push high and full low. Command 0 queues a
//   received byte, 2 writes one glyph column, 3 writes a glyph width, 1 is a
//   scroll tick. Only ticks give a result word.
//   Result side is a queue too: while empty is low the column word is on
//   red/green/blue_column, screen_blank and overflow; pop takes it.
//   Timing: a word is registered in the two-entry command queue and then
//   taken by the idle sequencer, so bytes and glyph writes go through at
//   one per cycle while no tick is in progress. With an empty byte queue a
//   tick gives a blank column from the drain request; a later glyph column
//   needs a glyph read. A color byte adds a read and check, a blank column
//   over a waiting character a check, a new one a check and a glyph read.
//   A result appears in the output register the cycle after it is formed.
//   Stall: if the result is not popped, the sequencer holds its column until
//   the register frees; the command queue still takes up to two words.
//   Reset: asynchronous, active low. The byte queue is empty, colors are 2,
//   the screen counts as blank and every glyph width reads as one; glyph
//   columns are undefined until written. No clearing pass is needed.
module led_text_scroll_column_engine import lts_pkg::*; #(
    parameter int QUEUE_DEPTH     = 16,
    parameter int MAX_GLYPH_WIDTH = 8,
    parameter int GAP_COLS        = 1,
    parameter int CHAR_COUNT      = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [7:0]  value_byte,
    input  logic [7:0]  glyph_code,
    input  logic [2:0]  glyph_column,
    input  logic [63:0] column_pixels,
    input  logic [3:0]  glyph_width,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] red_column,
    output logic [63:0] green_column,
    output logic [63:0] blue_column,
    output logic        screen_blank,
    output logic        overflow
);

    item_t cmd_item;
    logic  cmd_valid;
    logic  cmd_pop;
    res_t  back_res;
    logic  back_valid;
    logic  back_ready;

    // output register: one result word
    res_t  res_reg;
    logic  res_valid_reg;

    lts_front #(
        .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH),
        .CHAR_COUNT     (CHAR_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .value_byte   (value_byte),
        .glyph_code   (glyph_code),
        .glyph_column (glyph_column),
        .column_pixels(column_pixels),
        .glyph_width  (glyph_width),
        .cmd_valid    (cmd_valid),
        .cmd_item     (cmd_item),
        .cmd_pop      (cmd_pop)
    );

    lts_back #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH),
        .GAP_COLS       (GAP_COLS),
        .CHAR_COUNT     (CHAR_COUNT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_item (cmd_item),
        .cmd_pop  (cmd_pop),
        .res_valid(back_valid),
        .res      (back_res),
        .res_ready(back_ready)
    );

    // slot frees when empty or being popped this cycle
    assign back_ready = !res_valid_reg || pop;

    always_ff @(posedge clk)
    begin
        if (back_valid)
            res_reg <= back_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (back_valid)
            res_valid_reg <= 1'b1;
        else if (pop)
            res_valid_reg <= 1'b0;
    end

    assign empty        = !res_valid_reg;
    assign red_column   = res_reg.red_column;
    assign green_column = res_reg.green_column;
    assign blue_column  = res_reg.blue_column;
    assign screen_blank = res_reg.screen_blank;
    assign overflow     = res_reg.overflow;

endmodule
